[rtl/core/rule_tuple_to_ternary_key_macros.svh]
// assertion macros for the ternary key encoder
`ifndef RULE_TUPLE_TO_TERNARY_KEY_MACROS_SVH
`define RULE_TUPLE_TO_TERNARY_KEY_MACROS_SVH

`ifndef SYNTHESIS
`define RTTK_ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("rttk assertion failed");
`define RTTK_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rttk assertion failed");
`define RTTK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rttk assertion failed");
`else
`define RTTK_ASSERT_HOLDS(label, clk, rst, prop)
`define RTTK_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define RTTK_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/core/rttk_pkg.sv]
`default_nettype none

package rttk_pkg;

   localparam int AddrWidth   = 32;
   localparam int PrefixWidth = 6;
   localparam int PortWidth   = 16;
   localparam int ProtoWidth  = 8;
   localparam int UpperWidth  = 40;
   localparam int LowerWidth  = 64;

   localparam logic [PrefixWidth-1:0] PrefixFull  = 6'd32;
   localparam logic [PortWidth-1:0]   PortMax     = 16'hFFFF;
   localparam logic [PortWidth-1:0]   PortSplit   = 16'd1024;
   localparam logic [PortWidth-1:0]   PortMid     = 16'd512;
   localparam logic [PortWidth-1:0]   PortMidA    = 16'd640;
   localparam logic [PortWidth-1:0]   PortMidB    = 16'd656;
   localparam logic [PortWidth-1:0]   WildMid     = 16'h007F;
   localparam logic [PortWidth-1:0]   WildMidA    = 16'h000F;
   localparam logic [PortWidth-1:0]   WildMidB    = 16'h0003;
   localparam logic [PortWidth-1:0]   TrailLimit  = 16'd32767;
   localparam logic [PortWidth-1:0]   FixedLow    = 16'd20;
   localparam logic [PortWidth-1:0]   FixedHigh   = 16'd23;
   localparam logic [PortWidth-1:0]   FixedValue  = 16'h2800;
   localparam logic [PortWidth-1:0]   FixedCare   = 16'd16383;

   typedef struct packed {
      logic [AddrWidth-1:0]   source_address;
      logic [PrefixWidth-1:0] source_prefix_length;
      logic [AddrWidth-1:0]   target_address;
      logic [PrefixWidth-1:0] target_prefix_length;
      logic [PortWidth-1:0]   source_port_low;
      logic [PortWidth-1:0]   source_port_high;
      logic [PortWidth-1:0]   target_port_low;
      logic [PortWidth-1:0]   target_port_high;
      logic [ProtoWidth-1:0]  protocol_number;
      logic [ProtoWidth-1:0]  protocol_care;
   } req_type;

   typedef struct packed {
      logic [UpperWidth-1:0] key_value_upper;
      logic [LowerWidth-1:0] key_value_lower;
      logic [UpperWidth-1:0] key_care_upper;
      logic [LowerWidth-1:0] key_care_lower;
   } rsp_type;

   typedef struct packed {
      logic [AddrWidth-1:0] value;
      logic [AddrWidth-1:0] care;
   } addr_key_type;

   typedef struct packed {
      logic [PortWidth-1:0] value;
      logic [PortWidth-1:0] care;
   } port_key_type;

endpackage

`default_nettype wire

[rtl/core/rttk_addr_enc.sv]
`default_nettype none

module rttk_addr_enc (
   input  wire logic [rttk_pkg::AddrWidth-1:0]   address,
   input  wire logic [rttk_pkg::PrefixWidth-1:0] prefix_length,
   output rttk_pkg::addr_key_type                key
);

   logic [rttk_pkg::AddrWidth-1:0]   care;
   logic [rttk_pkg::PrefixWidth:0]   shift;

   always_comb begin
      shift = 7'd32 - {1'b0, prefix_length};
      if (prefix_length >= rttk_pkg::PrefixFull) begin
         care = '1;
      end else begin
         // a shift of the full width leaves all wildcards for prefix zero
         care = {rttk_pkg::AddrWidth{1'b1}} << shift;
      end
      key.care  = care;
      key.value = address & care;
   end

endmodule

`default_nettype wire

[rtl/core/rttk_port_enc.sv]
`default_nettype none

module rttk_port_enc (
   input  wire logic [rttk_pkg::PortWidth-1:0] port_low,
   input  wire logic [rttk_pkg::PortWidth-1:0] port_high,
   input  wire logic                           target_mode,
   output rttk_pkg::port_key_type              key
);

   logic [rttk_pkg::PortWidth:0]   low_plus_one;
   logic                           wide_span;
   logic [rttk_pkg::PortWidth-1:0] smear;
   logic [rttk_pkg::PortWidth-1:0] below_top_wild;
   logic [rttk_pkg::PortWidth-1:0] trail_wild;
   logic [rttk_pkg::PortWidth-1:0] low_minus_one;
   logic [rttk_pkg::PortWidth-1:0] double_minus_one;
   logic                           pow_pair;
   logic [rttk_pkg::PortWidth-1:0] wild;
   logic [rttk_pkg::PortWidth-1:0] care;

   always_comb begin
      low_plus_one = {1'b0, port_low} + 17'd1;
      wide_span    = {1'b0, port_high} > low_plus_one;

      // bits below the top one bit
      smear = port_low | (port_low >> 1);
      smear = smear | (smear >> 2);
      smear = smear | (smear >> 4);
      smear = smear | (smear >> 8);
      below_top_wild = (smear >> 1) & ~port_low;

      // trailing zeros, bit 15 never wildcard
      trail_wild = ((port_low & (~port_low + 16'd1)) - 16'd1) & rttk_pkg::TrailLimit;

      low_minus_one    = port_low - 16'd1;
      double_minus_one = (port_low << 1) - 16'd1;
      pow_pair = ((port_low & low_minus_one) == '0) && (port_high == double_minus_one);

      wild = '0;
      if (wide_span) begin
         if (port_low >= rttk_pkg::PortSplit) begin
            if (!target_mode || pow_pair) begin
               wild = below_top_wild;
            end else begin
               wild = trail_wild;
            end
         end else if (port_low < rttk_pkg::PortMid) begin
            wild = trail_wild;
         end else if (port_low == rttk_pkg::PortMid) begin
            wild = rttk_pkg::WildMid;
         end else if (port_low == rttk_pkg::PortMidA) begin
            wild = rttk_pkg::WildMidA;
         end else if (port_low == rttk_pkg::PortMidB) begin
            wild = rttk_pkg::WildMidB;
         end
      end
      care = ~wild;

      if (port_low == '0 && port_high == rttk_pkg::PortMax) begin
         key.value = '0;
         key.care  = '0;
      end else if (port_low == rttk_pkg::FixedLow && port_high == rttk_pkg::FixedHigh) begin
         key.value = rttk_pkg::FixedValue;
         key.care  = rttk_pkg::FixedCare;
      end else begin
         key.value = port_low & care;
         key.care  = care;
      end
   end

endmodule

`default_nettype wire

[rtl/core/rule_tuple_to_ternary_key.sv]
// Encodes one five-tuple rule into a 104-bit ternary key (value and care words, split
// into upper bits 103..64 and lower bits 63..0). The block takes one request every
// cycle while req_stall is low. An accepted request is captured in the input register;
// the address, port and protocol encoding is done in the logic between it and the
// result register, and the key is presented from the result register. Stall on the
// result side holds the result register, and the input register too once it is full;
// only then is it passed back as req_stall.
`default_nettype none

`include "rule_tuple_to_ternary_key_macros.svh"

module rule_tuple_to_ternary_key (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire rttk_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rttk_pkg::rsp_type rsp_data
);

   logic              hold_valid_ff;
   logic              hold_valid_in;
   rttk_pkg::req_type hold_data_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rttk_pkg::rsp_type rsp_data_ff;
   rttk_pkg::rsp_type rsp_data_in;
   logic              out_advance;

   rttk_pkg::addr_key_type src_addr_key;
   rttk_pkg::addr_key_type dst_addr_key;
   rttk_pkg::port_key_type src_port_key;
   rttk_pkg::port_key_type dst_port_key;
   logic [rttk_pkg::ProtoWidth-1:0] proto_value;
   logic [rttk_pkg::ProtoWidth-1:0] proto_care;
   logic [103:0] key_value;
   logic [103:0] key_care;

   always_comb begin
      out_advance   = !rsp_valid_ff || !rsp_stall;
      req_stall     = hold_valid_ff && !out_advance;
      hold_valid_in = req_stall ? hold_valid_ff : req_valid;
      rsp_valid_in  = out_advance ? hold_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         hold_data_ff <= req_data;
      end
      if (out_advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   rttk_addr_enc u_src_addr (
      .address       (hold_data_ff.source_address),
      .prefix_length (hold_data_ff.source_prefix_length),
      .key           (src_addr_key)
   );

   rttk_addr_enc u_dst_addr (
      .address       (hold_data_ff.target_address),
      .prefix_length (hold_data_ff.target_prefix_length),
      .key           (dst_addr_key)
   );

   rttk_port_enc u_src_port (
      .port_low    (hold_data_ff.source_port_low),
      .port_high   (hold_data_ff.source_port_high),
      .target_mode (1'b0),
      .key         (src_port_key)
   );

   rttk_port_enc u_dst_port (
      .port_low    (hold_data_ff.target_port_low),
      .port_high   (hold_data_ff.target_port_high),
      .target_mode (1'b1),
      .key         (dst_port_key)
   );

   always_comb begin
      if (hold_data_ff.protocol_care != '0) begin
         proto_value = hold_data_ff.protocol_number;
         proto_care  = '1;
      end else begin
         proto_value = '0;
         proto_care  = '0;
      end
      key_value = {src_addr_key.value, dst_addr_key.value, src_port_key.value,
                   dst_port_key.value, proto_value};
      key_care  = {src_addr_key.care, dst_addr_key.care, src_port_key.care,
                   dst_port_key.care, proto_care};
      rsp_data_in.key_value_upper = key_value[103:64];
      rsp_data_in.key_value_lower = key_value[63:0];
      rsp_data_in.key_care_upper  = key_care[103:64];
      rsp_data_in.key_care_lower  = key_care[63:0];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `RTTK_ASSERT_IMPLIES(a_stall_needs_item, clock, reset, req_stall, hold_valid_ff)
   `RTTK_ASSERT_NEXT(a_item_moves_out, clock, reset, hold_valid_ff && out_advance, rsp_valid_ff)
   `RTTK_ASSERT_NEXT(a_drain_empties, clock, reset,
      rsp_valid_ff && !rsp_stall && !hold_valid_ff, !rsp_valid_ff)
   `RTTK_ASSERT_HOLDS(a_wild_value_zero, clock, reset, !rsp_valid_ff ||
      (((rsp_data_ff.key_value_upper & ~rsp_data_ff.key_care_upper) == '0) &&
       ((rsp_data_ff.key_value_lower & ~rsp_data_ff.key_care_lower) == '0)))

endmodule

`default_nettype wire
